>>> design/rse_pkg.sv
package rse_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int RAND_W   = 31;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int DIVCNT_W = $clog2(RAND_W);

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PICK   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_REFUSED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_LAST,
        RD_REM
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    scan_start;
        logic    scan_step;
        t_rd_sel rd_sel;
        logic    wr_append;
        logic    wr_move;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    div_start;
        logic    div_step;
        logic    pick_capture;
        logic    out_load;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic full;
        logic empty;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

>>> design/rse_in_if.sv
interface rse_in_if;
    import rse_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [VALUE_W-1:0]  value;
    logic [RAND_W-1:0]          random_word;

    modport source (output valid, output opcode, output value, output random_word,
                    input ready);
    modport sink (input valid, input opcode, input value, input random_word,
                  output ready);
endinterface

>>> design/rse_out_if.sv
interface rse_out_if;
    import rse_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  picked_value;
    logic [COUNT_W-1:0]         member_count;

    modport source (output valid, output status, output picked_value,
                    output member_count, input ready);
    modport sink (input valid, input status, input picked_value,
                  input member_count, output ready);
endinterface

>>> design/rse_ctrl.sv
module rse_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [rse_pkg::OPCODE_W-1:0]  i_in_opcode,
    output logic                          o_in_ready,
    input  rse_pkg::t_sts                 i_sts,
    output rse_pkg::t_cmd                 o_cmd
);
    import rse_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DIV,
        S_PICK_RD,
        S_PICK_DATA,
        S_RESULT
    } t_state;

    t_state               r_state, n_state;
    t_status              r_status, n_status;
    logic [OPCODE_W-1:0]  r_op, n_op;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_op     = r_op;
        o_cmd    = '0;
        o_cmd.rd_sel     = RD_SCAN;
        o_cmd.out_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op       = i_in_opcode;
                    if (i_in_opcode == OP_INSERT || i_in_opcode == OP_REMOVE) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else if (i_in_opcode == OP_PICK) begin
                        if (i_sts.empty) begin
                            n_status = ST_EMPTY;
                            n_state  = S_RESULT;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end else begin
                        n_status = ST_REFUSED;
                        n_state  = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.hit) begin
                    if (r_op == OP_INSERT) begin
                        n_status = ST_REFUSED;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_MOVE_RD;
                    end
                end else if (i_sts.scan_end) begin
                    n_state = S_RESULT;
                    if (r_op == OP_REMOVE) begin
                        n_status = ST_REFUSED;
                    end else if (i_sts.full) begin
                        n_status = ST_FULL;
                    end else begin
                        o_cmd.wr_append = 1'b1;
                        o_cmd.cnt_inc   = 1'b1;
                        n_status        = ST_DONE;
                    end
                end
            end
            S_MOVE_RD: begin
                o_cmd.rd_sel = RD_LAST;
                n_state      = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // The last entry fills the freed slot; removing the last entry
                // just rewrites it before the count drops.
                o_cmd.wr_move = 1'b1;
                o_cmd.cnt_dec = 1'b1;
                n_status      = ST_DONE;
                n_state       = S_RESULT;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_PICK_RD;
                end
            end
            S_PICK_RD: begin
                o_cmd.rd_sel = RD_REM;
                n_state      = S_PICK_DATA;
            end
            S_PICK_DATA: begin
                o_cmd.pick_capture = 1'b1;
                n_status           = ST_DONE;
                n_state            = S_RESULT;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
        r_op <= n_op;
    end

endmodule

>>> design/rse_datapath.sv
module rse_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rse_pkg::t_cmd                       i_cmd,
    output rse_pkg::t_sts                       o_sts,
    input  logic signed [rse_pkg::VALUE_W-1:0]  i_value,
    input  logic [rse_pkg::RAND_W-1:0]          i_random_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rse_pkg::STATUS_W-1:0]        o_status,
    output logic signed [rse_pkg::VALUE_W-1:0]  o_picked_value,
    output logic [rse_pkg::COUNT_W-1:0]         o_member_count
);
    import rse_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0]   r_mem [CAPACITY];
    logic [VALUE_W-1:0]   r_rd_data;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [VALUE_W-1:0]   wr_data;

    logic [CW-1:0]        r_count;
    logic [VALUE_W-1:0]   r_value;
    logic [CW-1:0]        r_idx;
    logic                 r_cmp_valid;
    logic [AW-1:0]        r_cmp_addr;
    logic [AW-1:0]        r_slot;
    logic                 issue;

    logic [CW-1:0]        r_rem;
    logic [RAND_W-1:0]    r_dvd;
    logic [DIVCNT_W-1:0]  r_div_cnt;
    logic [CW:0]          rem_shift;
    logic [CW:0]          rem_diff;
    logic                 rem_ge;

    logic [VALUE_W-1:0]   r_pick;
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [VALUE_W-1:0]   r_out_pick;
    logic [CW-1:0]        r_out_count;
    logic [CW+COUNT_W-1:0] count_ext;

    assign issue = (r_idx < r_count);

    assign o_sts.hit      = r_cmp_valid && (r_rd_data == r_value);
    assign o_sts.scan_end = !r_cmp_valid && !issue;
    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.div_last = (r_div_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_SCAN: rd_addr = r_idx[AW-1:0];
            RD_LAST: rd_addr = AW'(r_count - CW'(1));
            RD_REM:  rd_addr = r_rem[AW-1:0];
            default: rd_addr = r_idx[AW-1:0];
        endcase
    end

    always_comb begin
        wr_en   = i_cmd.wr_append || i_cmd.wr_move;
        wr_addr = i_cmd.wr_move ? r_slot : r_count[AW-1:0];
        wr_data = i_cmd.wr_move ? r_rd_data : r_value;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Restoring division: one quotient bit per cycle, only the remainder is kept.
    assign rem_shift = {r_rem, r_dvd[RAND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, r_count};
    assign rem_ge    = (rem_shift >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_pick  <= '0;
        end
        if (i_cmd.pick_capture) begin
            r_pick <= r_rd_data;
        end
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_dvd     <= i_random_word;
            r_div_cnt <= DIVCNT_W'(RAND_W - 1);
        end else if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
            r_dvd     <= {r_dvd[RAND_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt - DIVCNT_W'(1);
        end
        if (i_cmd.scan_step && o_sts.hit) begin
            r_slot <= r_cmp_addr;
        end
        if (i_cmd.scan_step) begin
            r_cmp_addr <= r_idx[AW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_pick   <= r_pick;
            r_out_count  <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.scan_start) begin
                r_idx       <= '0;
                r_cmp_valid <= 1'b0;
            end else if (i_cmd.scan_step) begin
                // The compare acts in the cycle after its read address is issued.
                if (issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                r_cmp_valid <= issue;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign count_ext      = {{COUNT_W{1'b0}}, r_out_count};
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_picked_value = r_out_pick;
    assign o_member_count = count_ext[COUNT_W-1:0];

endmodule

>>> design/randomized_set_engine_core.sv
// Randomized set engine: a set of distinct signed 32-bit values held in a dense
// store of up to CAPACITY entries, with a live member count.
// i_req carries one word per operation: opcode (insert, remove, pick), value
// and random_word. o_rsp returns one word per request: status, picked_value
// (zero unless a pick succeeds) and member_count after the operation.
// Both channels complete a transfer on a clock edge with valid and ready high.
// Requests are processed one at a time; i_req.ready is high while the engine
// waits for a request.
// Insert and remove scan the occupied entries through the store's registered
// read port, one entry per cycle; a remove that hits then moves the last entry
// into the freed slot. Pick reduces random_word modulo the count with a
// bit-serial divider over all 31 bits of random_word and then reads the store.
// The result sits in an output register; a stalled receiver holds it, and the
// engine may take the next request meanwhile but waits to deliver its result.
// Synchronous reset empties the set; stored entries are not cleared, since
// only entries below the count are ever used.
module randomized_set_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rse_in_if.sink i_req,
    rse_out_if.source o_rsp
);
    import rse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_opcode (i_req.opcode),
        .o_in_ready  (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rse_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_value        (i_req.value),
        .i_random_word  (i_req.random_word),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_status       (o_rsp.status),
        .o_picked_value (o_rsp.picked_value),
        .o_member_count (o_rsp.member_count)
    );

endmodule

>>> bench/randomized_set_engine_core_test.sv
`timescale 1ns / 1ps

module randomized_set_engine_core_test;
    import rse_pkg::*;

    localparam int CAP          = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CALM_ITEMS   = 250;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_LIMIT = 60;

    // The fourth opcode has no function; the block answers it as refused.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] picked;
        logic [COUNT_W-1:0] count;
    } t_set_reply;

    // Mirrors the set contents and holds the replies still owed by the block.
    class set_mirror;
        logic [VALUE_W-1:0] members [CAP];
        int unsigned        live;
        t_set_reply         owed[$];
        int unsigned        failures;
        int unsigned        reports;
        int unsigned        checked;
        int unsigned        n_op [4];
        int unsigned        n_full;
        int unsigned        n_empty;

        function new();
            live     = 0;
            failures = 0;
            reports  = 0;
            checked  = 0;
            n_full   = 0;
            n_empty  = 0;
            foreach (n_op[i]) n_op[i] = 0;
        endfunction

        function int find_slot(logic [VALUE_W-1:0] v);
            for (int i = 0; i < live; i++) begin
                if (members[i] == v) return i;
            end
            return -1;
        endfunction

        function void note_request(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] v,
                                   logic [RAND_W-1:0] rw);
            t_set_reply r;
            int         slot;
            r.status = ST_REFUSED;
            r.picked = '0;
            n_op[op]++;
            case (op)
                OP_INSERT: begin
                    slot = find_slot(v);
                    if (slot >= 0) begin
                        r.status = ST_REFUSED;
                    end else if (live >= CAP) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        members[live] = v;
                        live++;
                        r.status = ST_DONE;
                    end
                end
                OP_REMOVE: begin
                    slot = find_slot(v);
                    if (slot >= 0) begin
                        live--;
                        members[slot] = members[live];
                        r.status = ST_DONE;
                    end
                end
                OP_PICK: begin
                    if (live == 0) begin
                        r.status = ST_EMPTY;
                        n_empty++;
                    end else begin
                        r.picked = members[rw % live];
                        r.status = ST_DONE;
                    end
                end
                default: ;
            endcase
            r.count = COUNT_W'(live);
            owed = {owed, r};
        endfunction

        function void report_mismatch(string field, logic [VALUE_W-1:0] want,
                                      logic [VALUE_W-1:0] got);
            failures++;
            if (reports < REPORT_LIMIT) begin
                reports++;
                $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            end
        endfunction

        function void check_reply(logic [STATUS_W-1:0] st, logic [VALUE_W-1:0] pv,
                                  logic [COUNT_W-1:0] cnt);
            t_set_reply e;
            checked++;
            if (owed.size() == 0) begin
                failures++;
                if (reports < REPORT_LIMIT) begin
                    reports++;
                    $error("result word arrived with no request waiting for it");
                end
                return;
            end
            e = owed.pop_front();
            if (st !== e.status) report_mismatch("status", e.status, st);
            if (pv !== e.picked) report_mismatch("picked_value", e.picked, pv);
            if (cnt !== e.count) report_mismatch("member_count", e.count, cnt);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    rse_in_if  req_if ();
    rse_out_if rsp_if ();

    set_mirror mirror = new();
    int        idle_pct;
    int        accepted;
    bit        long_hold_done;
    bit        growing;

    randomized_set_engine_core #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("** randomized_set_engine_core: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            mirror.check_reply(rsp_if.status, rsp_if.picked_value, rsp_if.member_count);
        end
    end

    // Result side: random stall bursts, plus one long hold-off that backs the
    // engine up until it refuses new request words.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && accepted >= HOLD_AT) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold_done = 1'b1;
            end else if (i_rst_n && $urandom_range(99) < idle_pct / 4) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(16, 1)) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v,
                             input logic [RAND_W-1:0] rw);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(16, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.value       <= v;
        req_if.random_word <= rw;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        mirror.note_request(op, v, rw);
        accepted++;
        @(negedge i_clk);
    endtask

    // Drifts between filling and draining the set so that both the full and
    // the empty store are reached again and again.
    task automatic send_random_word(output logic [OPCODE_W-1:0] op);
        logic [VALUE_W-1:0] v;
        logic [RAND_W-1:0]  rw;
        int                 roll;
        int                 live;
        live = mirror.live;
        if (growing && live == CAP && $urandom_range(3) == 0) begin
            growing = 1'b0;
        end else if (!growing && live == 0 && $urandom_range(3) == 0) begin
            growing = 1'b1;
        end

        roll = $urandom_range(99);
        if (roll < 4) begin
            op = OP_UNUSED;
        end else if (roll < 28) begin
            op = OP_PICK;
        end else if (roll < (growing ? 78 : 48)) begin
            op = OP_INSERT;
        end else begin
            op = OP_REMOVE;
        end

        roll = $urandom_range(99);
        if (live > 0 && roll < (op == OP_REMOVE ? 65 : 35)) begin
            if ($urandom_range(3) == 0) begin
                v = mirror.members[live-1];
            end else begin
                v = mirror.members[$urandom_range(live-1)];
            end
        end else if (roll < 75) begin
            v = $urandom;
        end else if (roll < 85) begin
            case ($urandom_range(3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end else begin
            // A narrow band of values makes repeats and misses likely.
            v = $urandom_range(15);
            v = v - 32'd8;
        end

        roll = $urandom_range(9);
        if (roll < 3) begin
            rw = RAND_W'($urandom_range(live + 2));
        end else if (roll == 3) begin
            rw = '1;
        end else begin
            rw = RAND_W'($urandom);
        end
        send_word(op, v, rw);
    endtask

    initial begin
        logic [OPCODE_W-1:0] op;
        int                  n;
        int                  sent;
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_INSERT;
        req_if.value       = '0;
        req_if.random_word = '0;
        i_rst_n            = 1'b0;
        idle_pct           = 0;
        accepted           = 0;
        long_hold_done     = 1'b0;
        growing            = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 20;
        send_word(OP_PICK,   32'h0000_0000, '1);
        send_word(OP_REMOVE, 32'd5,         '0);
        send_word(OP_UNUSED, 32'h7FFF_FFFF, '1);
        send_word(OP_INSERT, 32'h8000_0000, '0);
        send_word(OP_INSERT, 32'h7FFF_FFFF, '0);
        send_word(OP_INSERT, 32'h0000_0000, '0);
        send_word(OP_INSERT, 32'hFFFF_FFFF, '0);
        send_word(OP_INSERT, 32'h8000_0000, '0);
        send_word(OP_PICK,   32'h0000_0000, '0);
        send_word(OP_PICK,   32'hFFFF_FFFF, '1);
        // Removing a middle entry pulls the last one into its slot.
        send_word(OP_REMOVE, 32'h0000_0000, '0);
        send_word(OP_REMOVE, 32'd12345,     '0);
        send_word(OP_REMOVE, 32'hFFFF_FFFF, '0);
        send_word(OP_PICK,   32'h1234_5678, 31'd1);
        send_word(OP_INSERT, 32'h5555_5555, '1);
        send_word(OP_INSERT, 32'hAAAA_AAAA, '1);
        send_word(OP_REMOVE, 32'h8000_0000, '0);
        send_word(OP_PICK,   32'h0000_0000, 31'h4000_0000);
        send_word(OP_UNUSED, 32'h0000_0000, '0);
        send_word(OP_REMOVE, 32'h7FFF_FFFF, '0);
        send_word(OP_REMOVE, 32'h5555_5555, '0);
        send_word(OP_REMOVE, 32'hAAAA_AAAA, '0);
        send_word(OP_PICK,   32'h0000_0000, 31'd7);

        n    = 0;
        sent = 0;
        while (n < RANDOM_ITEMS) begin
            if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
                idle_pct = 0;
            end else if (sent % 150 == 0) begin
                case ($urandom_range(3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    2:       idle_pct = 30;
                    default: idle_pct = 50;
                endcase
            end
            send_random_word(op);
            sent++;
            if (op != OP_UNUSED) n++;
        end
        req_if.valid <= 1'b0;

        while (mirror.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d inserts, %0d removes, %0d picks, %0d unused.",
                 accepted, mirror.n_op[OP_INSERT], mirror.n_op[OP_REMOVE],
                 mirror.n_op[OP_PICK], mirror.n_op[OP_UNUSED]);
        $display("Inserts refused by a full set: %0d, picks on an empty set: %0d, %0d results.",
                 mirror.n_full, mirror.n_empty, mirror.checked);
        if (mirror.failures == 0 && mirror.owed.size() == 0) begin
            $display("** randomized_set_engine_core: PASSED **");
        end else begin
            $display("** randomized_set_engine_core: FAILED **");
        end
        $finish;
    end

endmodule
